@@ rtl/dwpi_pkg.sv @@
package dwpi_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KI    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RHO   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_UPPER = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOWER = 3'd5;

  localparam logic [15:0]        KP_RESET    = 16'd256;
  localparam logic [15:0]        KI_RESET    = 16'd0;
  localparam logic [15:0]        DT_RESET    = 16'd66;
  localparam logic [15:0]        RHO_RESET   = 16'd1966;
  localparam logic signed [15:0] UPPER_RESET = 16'sd25600;
  localparam logic signed [15:0] LOWER_RESET = -16'sd25600;

  typedef struct packed {
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        dt;
    logic [15:0]        rho;
    logic signed [15:0] upper;
    logic signed [15:0] lower;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR_MUL,
    OP_ERR_TAKE,
    OP_INC_MUL,
    OP_P_MUL,
    OP_I_MUL,
    OP_CMD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic wheel;
  } ctrl_t;

endpackage

@@ rtl/dwpi_if.sv @@
interface dwpi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_reference;
  logic signed [15:0] left_reference;
  logic signed [15:0] right_measured;
  logic signed [15:0] left_measured;

  modport source (output valid, right_reference, left_reference, right_measured,
                  left_measured, input ready);
  modport sink (input valid, right_reference, left_reference, right_measured,
                left_measured, output ready);
endinterface

interface dwpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_command;
  logic signed [15:0] left_command;

  modport source (output valid, right_command, left_command, input ready);
  modport sink (input valid, right_command, left_command, output ready);
endinterface

interface dwpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/dwpi_cfg.sv @@
module dwpi_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  input  logic [dwpi_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [15:0]                wr_data_i,
  output logic                       wr_ready_o,
  output dwpi_pkg::cfg_t             cfg_o
);
  import dwpi_pkg::*;

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= KP_RESET;
      cfg_q.ki    <= KI_RESET;
      cfg_q.dt    <= DT_RESET;
      cfg_q.rho   <= RHO_RESET;
      cfg_q.upper <= UPPER_RESET;
      cfg_q.lower <= LOWER_RESET;
    end else if (wr_valid_i) begin
      unique case (wr_index_i)
        REG_KP:    cfg_q.kp    <= wr_data_i;
        REG_KI:    cfg_q.ki    <= wr_data_i;
        REG_DT:    cfg_q.dt    <= wr_data_i;
        REG_RHO:   cfg_q.rho   <= wr_data_i;
        REG_UPPER: cfg_q.upper <= $signed(wr_data_i);
        REG_LOWER: cfg_q.lower <= $signed(wr_data_i);
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/dwpi_ctrl.sv @@
module dwpi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dwpi_pkg::ctrl_t ctrl_o
);
  import dwpi_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ERR_MUL  = 8'b0000_0010,
    ST_ERR_TAKE = 8'b0000_0100,
    ST_INC_MUL  = 8'b0000_1000,
    ST_P_MUL    = 8'b0001_0000,
    ST_I_MUL    = 8'b0010_0000,
    ST_CMD      = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   wheel_q, wheel_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    wheel_d     = wheel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl_o.op    = OP_NONE;
    ctrl_o.wheel = wheel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          wheel_d   = 1'b0;
          state_d   = ST_ERR_MUL;
        end
      end
      ST_ERR_MUL: begin
        ctrl_o.op = OP_ERR_MUL;
        state_d   = ST_ERR_TAKE;
      end
      ST_ERR_TAKE: begin
        ctrl_o.op = OP_ERR_TAKE;
        state_d   = ST_INC_MUL;
      end
      ST_INC_MUL: begin
        ctrl_o.op = OP_INC_MUL;
        state_d   = ST_P_MUL;
      end
      ST_P_MUL: begin
        ctrl_o.op = OP_P_MUL;
        state_d   = ST_I_MUL;
      end
      ST_I_MUL: begin
        ctrl_o.op = OP_I_MUL;
        state_d   = ST_CMD;
      end
      ST_CMD: begin
        ctrl_o.op = OP_CMD;
        if (!wheel_q) begin
          wheel_d = 1'b1;
          state_d = ST_ERR_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.op   = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/dwpi_dp.sv @@
module dwpi_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dwpi_pkg::ctrl_t    ctrl_i,
  input  dwpi_pkg::cfg_t     cfg_i,
  input  logic signed [15:0] right_reference_i,
  input  logic signed [15:0] left_reference_i,
  input  logic signed [15:0] right_measured_i,
  input  logic signed [15:0] left_measured_i,
  output logic signed [15:0] right_command_o,
  output logic signed [15:0] left_command_o
);
  import dwpi_pkg::*;

  logic signed [15:0] ref_q  [2];
  logic signed [15:0] meas_q [2];
  logic signed [31:0] integ_q [2];
  logic signed [16:0] last_e_q [2];
  logic signed [15:0] cmd_q [2];
  logic signed [16:0] e_q;
  logic signed [49:0] prod_q;
  logic signed [40:0] acc_q;
  logic signed [15:0] right_out_q, left_out_q;

  logic               w;
  logic signed [32:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [49:0] mul_p;
  logic signed [16:0] diff;
  logic signed [17:0] e_sum;
  logic signed [24:0] inc;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic signed [49:0] total;
  logic signed [33:0] cmd_full;
  logic signed [15:0] cmd_clamp;

  assign w     = ctrl_i.wheel;
  assign diff  = 17'(ref_q[w]) - 17'(meas_q[w]);
  assign e_sum = 18'(e_q) + 18'(last_e_q[w]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      OP_ERR_MUL: begin
        mul_a = 33'(diff);
        mul_b = cfg_i.rho;
      end
      OP_INC_MUL: begin
        mul_a = 33'(e_sum);
        mul_b = cfg_i.dt;
      end
      OP_P_MUL: begin
        mul_a = 33'(e_q);
        mul_b = cfg_i.kp;
      end
      OP_I_MUL: begin
        mul_a = 33'(integ_q[w]);
        mul_b = cfg_i.ki;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // trapezoid increment with saturating accumulate
  assign inc       = prod_q[33:9];
  assign integ_sum = 33'(integ_q[w]) + 33'(inc);
  always_comb begin
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      integ_sat = integ_sum[31:0];
    end
  end

  assign total    = 50'(acc_q) + prod_q;
  assign cmd_full = total[49:16];
  always_comb begin
    priority if (cmd_full > 34'(cfg_i.upper)) begin
      cmd_clamp = cfg_i.upper;
    end else if (cmd_full < 34'(cfg_i.lower)) begin
      cmd_clamp = cfg_i.lower;
    end else begin
      cmd_clamp = cmd_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        integ_q[i]  <= '0;
        last_e_q[i] <= '0;
      end
    end else begin
      unique case (ctrl_i.op)
        OP_P_MUL: integ_q[w]  <= integ_sat;
        OP_I_MUL: last_e_q[w] <= e_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        ref_q[0]  <= right_reference_i;
        ref_q[1]  <= left_reference_i;
        meas_q[0] <= right_measured_i;
        meas_q[1] <= left_measured_i;
      end
      OP_ERR_MUL, OP_INC_MUL, OP_P_MUL: prod_q <= mul_p;
      OP_ERR_TAKE: e_q <= prod_q[32:16];
      OP_I_MUL: begin
        acc_q  <= {prod_q[32:0], 8'd0};
        prod_q <= mul_p;
      end
      OP_CMD: cmd_q[w] <= cmd_clamp;
      OP_OUT: begin
        right_out_q <= cmd_q[0];
        left_out_q  <= cmd_q[1];
      end
      default: ;
    endcase
  end

  assign right_command_o = right_out_q;
  assign left_command_o  = left_out_q;

endmodule

@@ rtl/dual_wheel_pi_speed_controller.sv @@
// Channel | Dir | Words carried
// in_i    | in  | right/left reference, right/left measured speed (Q8.8)
// cfg_i   | in  | register index, 16 bit data; always ready
// out_o   | out | right/left clamped command (Q8.8)
//
// One word goes through the accept, six steps per wheel around the
// single shared 33x17 multiplier, and the transfer to the output register.
// Reset clears the integrals, the stored errors and the registers to defaults.
// A finished result waits in the output register; the next input word is
// taken meanwhile, and its result stalls only while the previous one is unread.
module dual_wheel_pi_speed_controller (
  input logic      clk_i,
  input logic      rst_ni,
  dwpi_in_if.sink  in_i,
  dwpi_cfg_if.sink cfg_i,
  dwpi_out_if.source out_o
);
  import dwpi_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  dwpi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  dwpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  dwpi_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .cfg_i             (cfg),
    .right_reference_i (in_i.right_reference),
    .left_reference_i  (in_i.left_reference),
    .right_measured_i  (in_i.right_measured),
    .left_measured_i   (in_i.left_measured),
    .right_command_o   (out_o.right_command),
    .left_command_o    (out_o.left_command)
  );

endmodule

@@ test/dual_wheel_pi_speed_controller_test.sv @@
module dual_wheel_pi_speed_controller_test;
  import dwpi_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int RandomPhases = 10;
  localparam int WindupPhase = 4;
  localparam int PhaseWords = 70;
  localparam int WindupPush = 170;
  localparam int WindupBack = 40;
  localparam int TailCycles = 40;
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;

  typedef enum logic [2:0] {
    PRE_KEEP,
    PRE_EXTREME,
    PRE_INVERTED,
    PRE_NO_DT,
    PRE_NO_RHO,
    PRE_WINDUP
  } preset_e;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } cmd_pair_t;

  typedef struct packed {
    preset_e            preset;
    logic signed [15:0] right_ref;
    logic signed [15:0] left_ref;
    logic signed [15:0] right_meas;
    logic signed [15:0] left_meas;
    logic               fixed;
    cmd_pair_t          want;
  } step_t;

  // fixed rows carry the command pair that follows directly from the setting
  step_t directed [0:17] = '{
    '{PRE_KEEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sd256, -16'sd256, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sd100, -16'sd100, 16'sd99, -16'sd99, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, '{16'sd0, 16'sd0}},
    '{PRE_EXTREME, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1,
      '{16'sh7FFF, 16'sh8000}},
    '{PRE_KEEP, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1,
      '{16'sh7FFF, 16'sh8000}},
    '{PRE_KEEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_INVERTED, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{-16'sd256, -16'sd256}},
    '{PRE_KEEP, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, -16'sd512, 16'sd512, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_NO_DT, 16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, '{16'sd0, 16'sd0}},
    '{PRE_NO_RHO, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, '{16'sd0, 16'sd0}},
    '{PRE_KEEP, 16'sd1234, -16'sd4321, 16'sd555, 16'sd777, 1'b1, '{16'sd0, 16'sd0}}
  };

  logic clk;
  logic rst_n;

  dwpi_in_if  in_bus ();
  dwpi_cfg_if cfg_bus ();
  dwpi_out_if out_bus ();

  dual_wheel_pi_speed_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .out_o (out_bus)
  );

  cfg_t        gains;
  int          right_integ;
  int          left_integ;
  int          right_err;
  int          left_err;
  cmd_pair_t   due_commands [$];
  cmd_pair_t   head;
  int          burst_left;
  int          errors = 0;
  int unsigned cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t timeout, %0d command words outstanding", $time, due_commands.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [15:0] wheel_command(input logic signed [15:0] target,
                                                       input logic signed [15:0] sensed,
                                                       inout int integ, inout int last_err);
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    longint diff;
    longint err;
    longint inc;
    longint sum;
    longint acc;
    longint cmd;
    hi = gains.upper;
    lo = gains.lower;
    diff = longint'(target) - longint'(sensed);
    err = (diff * longint'(gains.rho)) >>> 16;
    inc = ((err + longint'(last_err)) * longint'(gains.dt)) >>> 9;
    sum = longint'(integ) + inc;
    if (sum > IntegMax) sum = IntegMax;
    if (sum < IntegMin) sum = IntegMin;
    integ = int'(sum);
    acc = err * longint'(gains.kp) * 64'sd256 + longint'(gains.ki) * sum;
    cmd = acc >>> 16;
    // limits tested in this order, so inverted limits still pick one of the two
    if (cmd > longint'(hi)) cmd = longint'(hi);
    else if (cmd < longint'(lo)) cmd = longint'(lo);
    last_err = int'(err);
    return cmd[15:0];
  endfunction

  function automatic cfg_t preset_cfg(input preset_e p);
    case (p)
      PRE_EXTREME:  return '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000};
      PRE_INVERTED: return '{16'd256, 16'd0, 16'd66, 16'd1966, -16'sd256, 16'sd256};
      PRE_NO_DT:    return '{16'd256, 16'd512, 16'd0, 16'd30000, 16'sd25600, -16'sd25600};
      PRE_NO_RHO:   return '{16'd0, 16'd0, 16'd66, 16'd0, 16'sd25600, -16'sd25600};
      PRE_WINDUP:   return '{16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000};
      default:      return gains;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.kp = pick_gain();
    s.ki = pick_gain();
    case ($urandom_range(0, 4))
      0: s.dt = 16'd0;
      1: s.dt = 16'hFFFF;
      2: s.dt = 16'($urandom());
      default: s.dt = 16'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 3))
      0: s.rho = 16'd0;
      1: s.rho = 16'hFFFF;
      default: s.rho = 16'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: begin
        s.upper = 16'sh7FFF;
        s.lower = 16'sh8000;
      end
      1: begin
        s.upper = 16'(-int'($urandom_range(0, 8000)));
        s.lower = 16'($urandom_range(1, 8000));
      end
      2: begin
        s.upper = 16'($urandom());
        s.lower = 16'($urandom());
      end
      default: begin
        s.upper = 16'($urandom_range(0, 32767));
        s.lower = 16'(-int'($urandom_range(0, 32768)));
      end
    endcase
    return s;
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (due_commands.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_KP:    gains.kp    = val;
      REG_KI:    gains.ki    = val;
      REG_DT:    gains.dt    = val;
      REG_RHO:   gains.rho   = val;
      REG_UPPER: gains.upper = val;
      REG_LOWER: gains.lower = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input cfg_t s);
    settle();
    write_reg(REG_KP, s.kp);
    write_reg(REG_KI, s.ki);
    write_reg(REG_DT, s.dt);
    write_reg(REG_RHO, s.rho);
    write_reg(REG_UPPER, s.upper);
    // unmapped index, must leave every register alone
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom()));
    write_reg(REG_LOWER, s.lower);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_word(input logic signed [15:0] right_ref, input logic signed [15:0] left_ref,
                           input logic signed [15:0] right_meas,
                           input logic signed [15:0] left_meas,
                           input logic fixed, input cmd_pair_t want);
    int gap;
    cmd_pair_t calc;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 10));
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid           = 1'b1;
    in_bus.right_reference = right_ref;
    in_bus.left_reference  = left_ref;
    in_bus.right_measured  = right_meas;
    in_bus.left_measured   = left_meas;
    do @(posedge clk); while (!in_bus.ready);
    calc.right = wheel_command(right_ref, right_meas, right_integ, right_err);
    calc.left  = wheel_command(left_ref, left_meas, left_integ, left_err);
    due_commands.push_back(fixed ? want : calc);
  endtask

  task automatic send_random();
    logic signed [15:0] rr;
    logic signed [15:0] lr;
    logic signed [15:0] rm;
    logic signed [15:0] lm;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      rr = 16'($urandom());
      lr = 16'($urandom());
      rm = 16'($urandom());
      lm = 16'($urandom());
    end else if (kind < 17) begin
      rr = 16'($urandom());
      lr = 16'($urandom());
      rm = rr + 16'(int'($urandom_range(0, 512)) - 256);
      lm = lr + 16'(int'($urandom_range(0, 512)) - 256);
    end else begin
      rr = pick_speed();
      lr = pick_speed();
      rm = pick_speed();
      lm = pick_speed();
    end
    send_word(rr, lr, rm, lm, 1'b0, '0);
  endtask

  // drive both integrals into saturation when push_up is set, else pull them back
  task automatic send_windup(input int count, input logic push_up);
    logic signed [15:0] hi_speed;
    logic signed [15:0] lo_speed;
    repeat (count) begin
      hi_speed = 16'sh7FFF - 16'($urandom_range(0, 255));
      lo_speed = 16'sh8000 + 16'($urandom_range(0, 255));
      if (push_up) send_word(hi_speed, lo_speed, lo_speed, hi_speed, 1'b0, '0);
      else send_word(lo_speed, hi_speed, hi_speed, lo_speed, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_commands.size() == 0) begin
        errors++;
        $display("%0t unexpected word: right %0d left %0d", $time,
                 out_bus.right_command, out_bus.left_command);
      end else begin
        head = due_commands.pop_front();
        if (out_bus.right_command !== head.right) begin
          errors++;
          $display("%0t right_command: expected %0d actual %0d", $time, head.right,
                   out_bus.right_command);
        end
        if (out_bus.left_command !== head.left) begin
          errors++;
          $display("%0t left_command: expected %0d actual %0d", $time, head.left,
                   out_bus.left_command);
        end
      end
    end
  end

  initial begin
    int level;
    out_bus.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: level = 0;
        1: level = 25;
        2: level = 60;
        default: level = 90;
      endcase
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        out_bus.ready = ($urandom_range(0, 99) >= level);
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.right_reference = '0;
    in_bus.left_reference  = '0;
    in_bus.right_measured  = '0;
    in_bus.left_measured   = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    gains       = '{KP_RESET, KI_RESET, DT_RESET, RHO_RESET, UPPER_RESET, LOWER_RESET};
    right_integ = 0;
    left_integ  = 0;
    right_err   = 0;
    left_err    = 0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].preset != PRE_KEEP) load_setting(preset_cfg(directed[i].preset));
      send_word(directed[i].right_ref, directed[i].left_ref, directed[i].right_meas,
                directed[i].left_meas, directed[i].fixed, directed[i].want);
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == WindupPhase) begin
        load_setting(preset_cfg(PRE_WINDUP));
        send_windup(WindupPush, 1'b1);
        send_windup(WindupBack, 1'b0);
      end else begin
        load_setting(random_setting());
        repeat (PhaseWords) begin
          if ($urandom_range(0, 59) == 0) settle();
          send_random();
        end
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
